FILE: rtl/fskbcd_pkg.sv
// ----------------------------------------------------------------------------
// fskbcd_pkg
// Shared types, constants and the quarter-wave sine function of the FSK
// bit correlator demodulator.
// ----------------------------------------------------------------------------
package fskbcd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TRIG_W      = 15;
  localparam int ACC_W       = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam int BAUD      = 300;
  localparam int HALF_BAUD = 150;

  localparam int F_MARK_LO  = 980;
  localparam int F_SPACE_LO = 1180;
  localparam int F_MARK_HI  = 1650;
  localparam int F_SPACE_HI = 1850;

  typedef enum logic {
    BAND_LOW  = 1'b0,
    BAND_HIGH = 1'b1
  } band_t;

  // odd Taylor terms of sin(pi/2 * t), Q30
  localparam longint unsigned POLY_Q30 [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  // sin(pi/2 * r / quarter) in Q15, r in [0, quarter]
  function automatic logic [TRIG_W-1:0] quarter_sin(input int unsigned r,
                                                    input int unsigned angle_bits);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    int k;
    t  = 64'(r) << (30 - (angle_bits - 2));
    t2 = (t * t) >> 30;
    p  = POLY_Q30[5];
    for (k = 4; k >= 0; k--) begin
      p = POLY_Q30[k] - ((p * t2) >> 30);
    end
    p = (p * t) >> 30;
    p = (p + 64'd16384) >> 15;
    if (p > 64'd32767) begin
      p = 64'd32767;
    end
    return p[TRIG_W-1:0];
  endfunction

endpackage

FILE: rtl/fskbcd_sample_if.sv
// ----------------------------------------------------------------------------
// fskbcd_sample_if
// Valid/ready channel carrying one signed audio sample per item.
// ----------------------------------------------------------------------------
interface fskbcd_sample_if;
  import fskbcd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

FILE: rtl/fskbcd_bit_if.sv
// ----------------------------------------------------------------------------
// fskbcd_bit_if
// Valid/ready channel carrying one decided bit per item.
// ----------------------------------------------------------------------------
interface fskbcd_bit_if;
  logic valid;
  logic ready;
  logic bit_res;

  modport source(output valid, output bit_res, input ready);
  modport sink(input valid, input bit_res, output ready);
endinterface

FILE: rtl/fskbcd_front.sv
// ----------------------------------------------------------------------------
// fskbcd_front
// Accepts samples, tracks bit windows and tone phases, and converts the
// phase residues to table angles before handing items to the queue.
// ----------------------------------------------------------------------------
module fskbcd_front #(
  parameter int AUDIO_RATE = 8000,
  parameter int ANGLE_BITS = 12
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  fskbcd_pkg::band_t                             band,
  fskbcd_sample_if.sink                                 audio,
  output logic                                          push,
  output logic [2*ANGLE_BITS+fskbcd_pkg::SAMPLE_W:0]    push_data,
  input  logic                                          q_full
);
  import fskbcd_pkg::*;

  localparam int RES_W = $clog2(AUDIO_RATE);
  localparam int NUM_W = RES_W + ANGLE_BITS;
  localparam int RCP_W = ANGLE_BITS + 1;
  localparam int Q_W   = ANGLE_BITS + 1;
  localparam int PRD_W = NUM_W + RCP_W;

  localparam longint unsigned RECIP = (64'd1 << NUM_W) / AUDIO_RATE;

  localparam logic [RCP_W-1:0] RECIP_V  = RCP_W'(RECIP);
  localparam logic [NUM_W-1:0] HALF_SR  = NUM_W'(AUDIO_RATE / 2);
  localparam logic [NUM_W:0]   SR_EXT   = (NUM_W + 1)'(AUDIO_RATE);
  localparam logic [RES_W:0]   SR_RES   = (RES_W + 1)'(AUDIO_RATE);
  localparam logic [RES_W:0]   FM_LO    = (RES_W + 1)'(F_MARK_LO);
  localparam logic [RES_W:0]   FS_LO    = (RES_W + 1)'(F_SPACE_LO);
  localparam logic [RES_W:0]   FM_HI    = (RES_W + 1)'(F_MARK_HI);
  localparam logic [RES_W:0]   FS_HI    = (RES_W + 1)'(F_SPACE_HI);
  localparam logic [7:0]       LEN_BASE = 8'(AUDIO_RATE / BAUD);
  localparam logic [9:0]       SR_MOD   = 10'(AUDIO_RATE % BAUD);
  localparam logic [9:0]       BAUD_V   = 10'(BAUD);
  localparam logic [9:0]       BAUD2_V  = 10'(2 * BAUD);
  localparam logic [9:0]       HBAUD_V  = 10'(HALF_BAUD);

  logic [7:0]       cnt;
  logic [9:0]       bres;
  logic [RES_W-1:0] res_m;
  logic [RES_W-1:0] res_s;

  logic [7:0]       cnt_inc;
  logic [7:0]       len;
  logic [9:0]       t10;
  logic [9:0]       bres_sum;
  logic [9:0]       bres_next;
  logic [RES_W:0]   fm;
  logic [RES_W:0]   fs;
  logic [RES_W:0]   sum_m;
  logic [RES_W:0]   sum_s;
  logic [RES_W-1:0] res_m_next;
  logic [RES_W-1:0] res_s_next;
  logic [NUM_W-1:0] num_m;
  logic [NUM_W-1:0] num_s;
  logic             last;
  logic             fadv;
  logic             accept;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       s1_last;
  logic [NUM_W-1:0]           s1_num_m;
  logic [NUM_W-1:0]           s1_num_s;

  logic                       s2_valid;
  logic signed [SAMPLE_W-1:0] s2_sample;
  logic                       s2_last;
  logic [NUM_W-1:0]           s2_num_m;
  logic [NUM_W-1:0]           s2_num_s;
  logic [Q_W-1:0]             s2_q_m;
  logic [Q_W-1:0]             s2_q_s;

  logic [PRD_W-1:0]      prod_m;
  logic [PRD_W-1:0]      prod_s;
  logic [ANGLE_BITS-1:0] ang_m;
  logic [ANGLE_BITS-1:0] ang_s;

  // quotient estimate is low by at most one
  function automatic logic [ANGLE_BITS-1:0] fix_angle(input logic [Q_W-1:0]   q,
                                                      input logic [NUM_W-1:0] num);
    logic [NUM_W:0] qs;
    logic [NUM_W:0] rem;
    logic [Q_W-1:0] qf;
    qs  = (NUM_W + 1)'(q) * SR_EXT;
    rem = {1'b0, num} - qs;
    qf  = (rem >= SR_EXT) ? q + 1'b1 : q;
    return qf[ANGLE_BITS-1:0];
  endfunction

  always_comb begin
    fm = (band == BAND_HIGH) ? FM_HI : FM_LO;
    fs = (band == BAND_HIGH) ? FS_HI : FS_LO;

    t10 = bres + SR_MOD + HBAUD_V;
    len = LEN_BASE
        + ((t10 >= BAUD2_V) ? 8'd2 : ((t10 >= BAUD_V) ? 8'd1 : 8'd0))
        - ((bres >= HBAUD_V) ? 8'd1 : 8'd0);
    cnt_inc = cnt + 8'd1;
    last    = cnt_inc >= len;

    bres_sum  = bres + SR_MOD;
    bres_next = (bres_sum >= BAUD_V) ? bres_sum - BAUD_V : bres_sum;

    sum_m      = {1'b0, res_m} + fm;
    sum_s      = {1'b0, res_s} + fs;
    res_m_next = (sum_m >= SR_RES) ? RES_W'(sum_m - SR_RES) : sum_m[RES_W-1:0];
    res_s_next = (sum_s >= SR_RES) ? RES_W'(sum_s - SR_RES) : sum_s[RES_W-1:0];

    num_m = {res_m, {ANGLE_BITS{1'b0}}} + HALF_SR;
    num_s = {res_s, {ANGLE_BITS{1'b0}}} + HALF_SR;

    prod_m = PRD_W'(s1_num_m) * PRD_W'(RECIP_V);
    prod_s = PRD_W'(s1_num_s) * PRD_W'(RECIP_V);

    ang_m = fix_angle(s2_q_m, s2_num_m);
    ang_s = fix_angle(s2_q_s, s2_num_s);

    fadv        = !(s2_valid && q_full);
    audio.ready = fadv;
    accept      = audio.valid && fadv;
    push        = s2_valid && !q_full;
    push_data   = {s2_last, ang_s, ang_m, s2_sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      bres     <= '0;
      res_m    <= '0;
      res_s    <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          cnt   <= '0;
          bres  <= bres_next;
          res_m <= '0;
          res_s <= '0;
        end else begin
          cnt   <= cnt_inc;
          res_m <= res_m_next;
          res_s <= res_s_next;
        end
      end
      if (fadv) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      s1_sample <= audio.sample;
      s1_last   <= last;
      s1_num_m  <= num_m;
      s1_num_s  <= num_s;
      s2_sample <= s1_sample;
      s2_last   <= s1_last;
      s2_num_m  <= s1_num_m;
      s2_num_s  <= s1_num_s;
      s2_q_m    <= prod_m[NUM_W +: Q_W];
      s2_q_s    <= prod_s[NUM_W +: Q_W];
    end
  end

  a_win_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> cnt == '0 && res_m == '0 && res_s == '0)
    else $error("window state not cleared after window end");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt < len)
    else $error("sample count past window length");

endmodule

FILE: rtl/fskbcd_queue.sv
// ----------------------------------------------------------------------------
// fskbcd_queue
// Short register FIFO between the front and the correlator back end.
// ----------------------------------------------------------------------------
module fskbcd_queue #(
  parameter int DATA_W = 41
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);
  import fskbcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

FILE: rtl/fskbcd_rom.sv
// ----------------------------------------------------------------------------
// fskbcd_rom
// Quarter-wave sine table, Q15, two registered read ports.
// ----------------------------------------------------------------------------
module fskbcd_rom #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ANGLE_BITS-2:0]             addr_a,
  input  logic [ANGLE_BITS-2:0]             addr_b,
  output logic [fskbcd_pkg::TRIG_W-1:0]     data_a,
  output logic [fskbcd_pkg::TRIG_W-1:0]     data_b
);
  import fskbcd_pkg::*;

  localparam int DEPTH = (1 << (ANGLE_BITS - 2)) + 1;

  logic [TRIG_W-1:0] tab [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam logic [TRIG_W-1:0] V = quarter_sin(i, ANGLE_BITS);
    assign tab[i] = V;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= tab[addr_a];
      data_b <= tab[addr_b];
    end
  end

endmodule

FILE: rtl/fskbcd_back.sv
// ----------------------------------------------------------------------------
// fskbcd_back
// Tone lookup, sample-by-tone products, window accumulators and the
// mark/space energy decision.
// ----------------------------------------------------------------------------
module fskbcd_back #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [2*ANGLE_BITS+fskbcd_pkg::SAMPLE_W:0] q_data,
  input  logic                                       q_empty,
  output logic                                       pop,
  fskbcd_bit_if.source                               decision
);
  import fskbcd_pkg::*;

  localparam int ADDR_W = ANGLE_BITS - 1;
  localparam int PROD_W = 18;
  localparam int SQ_W   = 2 * ACC_W - 1;
  localparam int EN_W   = SQ_W + 1;

  localparam logic [ADDR_W-1:0]     QUARTER   = ADDR_W'(1 << (ANGLE_BITS - 2));
  localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

  logic                       adv;
  logic signed [SAMPLE_W-1:0] q_sample;
  logic [ANGLE_BITS-1:0]      q_ang_m;
  logic [ANGLE_BITS-1:0]      q_ang_s;
  logic                       q_last;
  logic [ADDR_W:0]            ta [4];

  logic [TRIG_W-1:0]          trig [4];
  logic                       b1_valid;
  logic                       b1_last;
  logic signed [SAMPLE_W-1:0] b1_sample;
  logic [3:0]                 b1_neg;

  logic signed [TRIG_W+1:0]   tv [4];
  logic signed [32:0]         prod_full [4];

  logic                       b2_valid;
  logic                       b2_last;
  logic signed [PROD_W-1:0]   b2_prod [4];

  logic signed [ACC_W-1:0]    acc [4];
  logic signed [ACC_W-1:0]    acc_new [4];

  logic                       b3_valid;
  logic signed [ACC_W-1:0]    b3_e [4];
  logic signed [2*ACC_W-1:0]  sq_full [4];

  logic                       b4_valid;
  logic [SQ_W-1:0]            b4_sq [4];

  logic                       b5_valid;
  logic [EN_W-1:0]            b5_em;
  logic [EN_W-1:0]            b5_es;

  logic                       out_valid;
  logic                       out_bit;

  // {negate, quarter-table address}
  function automatic logic [ADDR_W:0] trig_addr(input logic [ANGLE_BITS-1:0] a);
    logic [ADDR_W-1:0] r;
    r = {1'b0, a[ANGLE_BITS-3:0]};
    return {a[ANGLE_BITS-1], a[ANGLE_BITS-2] ? QUARTER - r : r};
  endfunction

  always_comb begin
    // hold only when a new bit would land on a bit still waiting
    adv      = !(b5_valid && out_valid && !decision.ready);
    pop      = adv && !q_empty;
    q_sample = q_data[SAMPLE_W-1:0];
    q_ang_m  = q_data[SAMPLE_W +: ANGLE_BITS];
    q_ang_s  = q_data[SAMPLE_W+ANGLE_BITS +: ANGLE_BITS];
    q_last   = q_data[2*ANGLE_BITS+SAMPLE_W];

    ta[0] = trig_addr(q_ang_m + QUARTER_A);
    ta[1] = trig_addr(q_ang_m);
    ta[2] = trig_addr(q_ang_s + QUARTER_A);
    ta[3] = trig_addr(q_ang_s);

    for (int i = 0; i < 4; i++) begin
      tv[i]        = b1_neg[i] ? -$signed({2'b00, trig[i]}) : $signed({2'b00, trig[i]});
      prod_full[i] = b1_sample * tv[i];
      acc_new[i]   = acc[i] + ACC_W'(b2_prod[i]);
      sq_full[i]   = b3_e[i] * b3_e[i];
    end

    decision.valid   = out_valid;
    decision.bit_res = out_bit;
  end

  fskbcd_rom #(.ANGLE_BITS(ANGLE_BITS)) u_rom_mark (
    .clk    (clk),
    .en     (adv),
    .addr_a (ta[0][ADDR_W-1:0]),
    .addr_b (ta[1][ADDR_W-1:0]),
    .data_a (trig[0]),
    .data_b (trig[1])
  );

  fskbcd_rom #(.ANGLE_BITS(ANGLE_BITS)) u_rom_space (
    .clk    (clk),
    .en     (adv),
    .addr_a (ta[2][ADDR_W-1:0]),
    .addr_b (ta[3][ADDR_W-1:0]),
    .data_a (trig[2]),
    .data_b (trig[3])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      b4_valid  <= 1'b0;
      b5_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (adv) begin
        b1_valid <= pop;
        b2_valid <= b1_valid;
        b3_valid <= b2_valid && b2_last;
        b4_valid <= b3_valid;
        b5_valid <= b4_valid;
        if (b2_valid) begin
          for (int i = 0; i < 4; i++) begin
            acc[i] <= b2_last ? '0 : acc_new[i];
          end
        end
      end
      if (adv && b5_valid) begin
        out_valid <= 1'b1;
      end else if (decision.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sample <= q_sample;
      b1_last   <= q_last;
      b1_neg    <= {ta[3][ADDR_W], ta[2][ADDR_W], ta[1][ADDR_W], ta[0][ADDR_W]};
      b2_last   <= b1_last;
      for (int i = 0; i < 4; i++) begin
        b2_prod[i] <= PROD_W'(prod_full[i] >>> 15);
        b3_e[i]    <= acc_new[i];
        b4_sq[i]   <= sq_full[i][SQ_W-1:0];
      end
      b5_em <= {1'b0, b4_sq[0]} + {1'b0, b4_sq[1]};
      b5_es <= {1'b0, b4_sq[2]} + {1'b0, b4_sq[3]};
      if (b5_valid) begin
        out_bit <= b5_em >= b5_es;
      end
    end
  end

  a_sums_clear: assert property (@(posedge clk) disable iff (rst)
    adv && b2_valid && b2_last |=>
      acc[0] == '0 && acc[1] == '0 && acc[2] == '0 && acc[3] == '0)
    else $error("correlator sums not cleared at window end");

endmodule

FILE: rtl/fsk_bit_correlator_demod_core.sv
// ----------------------------------------------------------------------------
// fsk_bit_correlator_demod_core
// 300-baud FSK bit demodulator: per-window tone correlation and energy
// decision between mark and space.
//
// audio: one signed 16-bit sample per item (valid/ready).
// decision: one bit per completed bit window, 1 for mark, 0 for space.
// cfg_we/cfg_wdata: band select, 0 = 980/1180 Hz, 1 = 1650/1850 Hz; write
// only while no samples are in flight.
// Throughput: one sample per cycle while the back end is not held. The front
// (window and phase tracking, angle conversion) and the back (sine table,
// four multiply-accumulates, energy compare) each run one item per cycle
// when not held, and are joined by a four-entry queue.
// The last sample of a window passes the front's s1 and s2 registers, the queue,
// the back end's b1 to b5 registers and the output register to reach decision.
// Reset clears the band to the low channel, the window position, the phases
// and the sums; no clearing pass is needed.
// A stalled decision channel keeps its bit in the output register while the
// back end runs on; only when the next bit is ready does the back end hold,
// the queue fill and audio.ready drop until the waiting bit is taken.
// ----------------------------------------------------------------------------
module fsk_bit_correlator_demod_core #(
  parameter int AUDIO_RATE = 8000,
  parameter int ANGLE_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  fskbcd_sample_if.sink audio,
  fskbcd_bit_if.source  decision
);
  import fskbcd_pkg::*;

  localparam int DATA_W = 2 * ANGLE_BITS + SAMPLE_W + 1;

  band_t             band;
  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              q_full;
  logic              pop;
  logic [DATA_W-1:0] pop_data;
  logic              q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= BAND_LOW;
    end else if (cfg_we) begin
      band <= band_t'(cfg_wdata);
    end
  end

  fskbcd_front #(.AUDIO_RATE(AUDIO_RATE), .ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .band      (band),
    .audio     (audio),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  fskbcd_queue #(.DATA_W(DATA_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fskbcd_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (pop_data),
    .q_empty  (q_empty),
    .pop      (pop),
    .decision (decision)
  );

endmodule

FILE: tb/sv/fsk_bit_correlator_demod_core_tb.sv
// ----------------------------------------------------------------------------
// fsk_bit_correlator_demod_core_tb
// Self-checking bench for the 300-baud FSK demodulator core. Audio samples go
// in through the valid/ready audio channel under several idle and stall mixes
// and on both bands. A bit-exact window and correlator predictor builds the
// expected bit stream. Every bit taken from the decision channel is checked
// against it.
// ----------------------------------------------------------------------------
module fsk_bit_correlator_demod_core_tb;
  import fskbcd_pkg::*;

  localparam int RATE      = 8000;
  localparam int ANG_BITS  = 12;
  localparam int ANG_SIZE  = 1 << ANG_BITS;
  localparam int ANG_QTR   = ANG_SIZE / 4;
  localparam int BIT_RATE  = 300;
  localparam int RES_STEP  = RATE % BIT_RATE;
  localparam int TAIL_CYC  = 24;
  localparam int PHASE_LEN = 72;
  localparam int MIN_BITS  = 24;

  localparam int MARK_LO  = 980;
  localparam int SPACE_LO = 1180;
  localparam int MARK_HI  = 1650;
  localparam int SPACE_HI = 1850;

  localparam logic [7:0] BAND_PLAN = 8'b1010_0110;

  // odd Taylor terms of sin(pi/2 * t), Q30
  localparam longint unsigned SIN_POLY [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  fskbcd_sample_if audio_ch();
  fskbcd_bit_if    bit_ch();

  fsk_bit_correlator_demod_core #(
    .AUDIO_RATE(RATE),
    .ANGLE_BITS(ANG_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .audio    (audio_ch),
    .decision (bit_ch)
  );

  int sin_lut [ANG_SIZE];

  // predictor state
  band_t              cur_band = BAND_LOW;
  logic [7:0]         win_cnt  = '0;
  logic [9:0]         win_res  = '0;
  logic [15:0]        mark_ph  = '0;
  logic [15:0]        space_ph = '0;
  logic signed [23:0] mark_i   = '0;
  logic signed [23:0] mark_q   = '0;
  logic signed [23:0] space_i  = '0;
  logic signed [23:0] space_q  = '0;

  bit                 bits_due [$];
  logic signed [15:0] pcm_backlog [$];

  // stimulus-side window tracking
  int gen_pos = 0;
  int gen_res = 0;
  int gen_windows = 0;

  int queued_total = 0;
  int accepted_total = 0;
  int bits_checked = 0;
  int bad_cnt = 0;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  logic audio_took = 1'b0;
  bit want_bit;

  function automatic int quarter_wave(input int unsigned r);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned acc;
    t = r;
    t = t << (30 - (ANG_BITS - 2));
    t2 = (t * t) >> 30;
    acc = SIN_POLY[5];
    for (int k = 4; k >= 0; k--) begin
      acc = SIN_POLY[k] - ((acc * t2) >> 30);
    end
    acc = (acc * t) >> 30;
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) begin
      acc = 64'd32767;
    end
    return int'(acc);
  endfunction

  function automatic int unsigned phase_angle(input int unsigned res);
    return ((res * ANG_SIZE + RATE / 2) / RATE) % ANG_SIZE;
  endfunction

  function automatic int window_len(input int r);
    return (r + RATE + BIT_RATE / 2) / BIT_RATE - (r + BIT_RATE / 2) / BIT_RATE;
  endfunction

  function automatic logic signed [23:0] mix(input logic signed [15:0] s, input int trig);
    longint p;
    p = longint'(s) * longint'(trig);
    return 24'(p >>> 15);
  endfunction

  task automatic correlate_sample(input logic signed [15:0] s);
    int unsigned mk_ang;
    int unsigned sp_ang;
    int fm;
    int fs;
    longint mark_e;
    longint space_e;
    fm = (cur_band == BAND_HIGH) ? MARK_HI : MARK_LO;
    fs = (cur_band == BAND_HIGH) ? SPACE_HI : SPACE_LO;
    mk_ang = phase_angle(mark_ph);
    sp_ang = phase_angle(space_ph);
    mark_i  = mark_i  + mix(s, sin_lut[(mk_ang + ANG_QTR) % ANG_SIZE]);
    mark_q  = mark_q  + mix(s, sin_lut[mk_ang]);
    space_i = space_i + mix(s, sin_lut[(sp_ang + ANG_QTR) % ANG_SIZE]);
    space_q = space_q + mix(s, sin_lut[sp_ang]);
    mark_ph = mark_ph + 16'(fm);
    if (mark_ph >= RATE) begin
      mark_ph = mark_ph - 16'(RATE);
    end
    space_ph = space_ph + 16'(fs);
    if (space_ph >= RATE) begin
      space_ph = space_ph - 16'(RATE);
    end
    win_cnt = win_cnt + 8'd1;
    if (win_cnt >= window_len(win_res)) begin
      mark_e  = longint'(mark_i) * mark_i + longint'(mark_q) * mark_q;
      space_e = longint'(space_i) * space_i + longint'(space_q) * space_q;
      bits_due.insert(bits_due.size(), bit'(mark_e >= space_e));
      win_res  = 10'((win_res + RES_STEP) % BIT_RATE);
      win_cnt  = '0;
      mark_ph  = '0;
      space_ph = '0;
      mark_i   = '0;
      mark_q   = '0;
      space_i  = '0;
      space_q  = '0;
    end
  endtask

  task automatic queue_sample(input int v);
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    pcm_backlog.insert(pcm_backlog.size(), 16'(v));
    queued_total++;
    gen_pos++;
    if (gen_pos >= window_len(gen_res)) begin
      gen_pos = 0;
      gen_res = (gen_res + RES_STEP) % BIT_RATE;
      gen_windows++;
    end
  endtask

  // n samples of one kind: clean or noisy tone, off-band tone, noise, rails, near zero
  task automatic emit_segment(input int n);
    int kind;
    int freq;
    int amp;
    int spread;
    int offs;
    int v;
    kind   = $urandom_range(9);
    amp    = $urandom_range(32767, 1);
    spread = $urandom_range(amp / 4);
    offs   = $urandom_range(ANG_SIZE - 1);
    if (kind == 6) begin
      if (cur_band == BAND_HIGH) begin
        freq = $urandom_range(1) ? MARK_LO : SPACE_LO;
      end else begin
        freq = $urandom_range(1) ? MARK_HI : SPACE_HI;
      end
    end else if (cur_band == BAND_HIGH) begin
      freq = $urandom_range(1) ? MARK_HI : SPACE_HI;
    end else begin
      freq = $urandom_range(1) ? MARK_LO : SPACE_LO;
    end
    for (int k = 0; k < n; k++) begin
      case (kind)
        7: begin
          v = $signed(16'($urandom()));
        end
        8: begin
          v = $urandom_range(1) ? 32767 : -32768;
        end
        9: begin
          v = int'($urandom_range(8)) - 4;
        end
        default: begin
          v = (amp * sin_lut[(phase_angle((freq * gen_pos) % RATE) + offs) % ANG_SIZE]) >>> 15;
          v = v + int'($urandom_range(2 * spread)) - spread;
        end
      endcase
      queue_sample(v);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (accepted_total != queued_total || bits_due.size() != 0);
    repeat (TAIL_CYC) @(negedge clk);
  endtask

  task automatic set_band(input band_t b);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_band = b;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("fsk_bit_correlator_demod_core verification failed");
    $finish;
  end

  // audio source
  always @(negedge clk) begin
    if (rst) begin
      audio_ch.valid <= 1'b0;
    end else if (!audio_ch.valid || audio_took) begin
      if (pcm_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        audio_ch.valid <= 1'b1;
        audio_ch.sample <= pcm_backlog.pop_front();
      end else begin
        audio_ch.valid <= 1'b0;
      end
    end
  end

  // decision sink
  always @(negedge clk) begin
    if (rst) begin
      bit_ch.ready <= 1'b0;
    end else begin
      bit_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      audio_took <= 1'b0;
    end else begin
      audio_took <= audio_ch.valid && audio_ch.ready;
      if (audio_ch.valid && audio_ch.ready) begin
        accepted_total++;
        correlate_sample(audio_ch.sample);
      end
      if (bit_ch.valid && bit_ch.ready) begin
        if (bits_due.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("unexpected decision bit %0b with none pending", bit_ch.bit_res);
          end
        end else begin
          want_bit = bits_due.pop_front();
          bits_checked++;
          if (bit_ch.bit_res !== want_bit) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("decision bit %0d: expected %0b, got %0b",
                       bits_checked, want_bit, bit_ch.bit_res);
            end
          end
        end
      end
    end
  end

  initial begin
    int q;
    int r;
    int v;
    int start;
    int directed [24];
    audio_ch.valid = 1'b0;
    audio_ch.sample = '0;
    bit_ch.ready = 1'b0;
    for (int i = 0; i < ANG_SIZE; i++) begin
      q = i / ANG_QTR;
      r = i % ANG_QTR;
      v = quarter_wave((q % 2) ? ANG_QTR - r : r);
      sin_lut[i] = (q >= 2) ? -v : v;
    end
    directed = '{0, 32767, -32768, 1, -1, 21845, -21846, 32767, 32767, -32768, -32768, 0,
                 -32768, 32767, 256, -256, 16384, -16384, 32767, -32768, 4095, -4096, 0, -1};

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // opening samples; band flips in the middle of the first window
    set_band(BAND_LOW);
    for (int i = 0; i < 24; i++) begin
      if (i == 12) begin
        set_band(BAND_HIGH);
      end
      queue_sample(directed[i]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_band(band_t'(BAND_PLAN[ph]));
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          dst_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 47;
          dst_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          dst_stall_pct = 47;
        end
        default: begin
          src_idle_pct = 33;
          dst_stall_pct = 33;
        end
      endcase
      start = queued_total;
      while (queued_total - start < PHASE_LEN || (ph == 7 && gen_windows < MIN_BITS)) begin
        emit_segment(window_len(gen_res) - gen_pos);
      end
      // sometimes leave the window open across the next band write
      if ($urandom_range(1)) begin
        emit_segment($urandom_range(window_len(gen_res) - gen_pos - 1));
      end
    end

    wait_idle();
    $display("%0d audio samples over 8 band/stall phases, %0d decision bits compared",
             accepted_total, bits_checked);
    if (bad_cnt == 0 && bits_due.size() == 0) begin
      $display("fsk_bit_correlator_demod_core verification clean");
    end else begin
      $display("fsk_bit_correlator_demod_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fskbcd_pkg.sv
rtl/fskbcd_sample_if.sv
rtl/fskbcd_bit_if.sv
rtl/fskbcd_front.sv
rtl/fskbcd_queue.sv
rtl/fskbcd_rom.sv
rtl/fskbcd_back.sv
rtl/fsk_bit_correlator_demod_core.sv
tb/sv/fsk_bit_correlator_demod_core_tb.sv
